// ===== src/sts_pkg.sv =====
// Shared types, codes and constants for the script token scanner.
// No dependencies; imported by every other file of the block but sts_if.
`default_nettype none
package sts_pkg;

  localparam int unsigned MAX_TOKEN_BYTES_DEF = 256;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  localparam logic [1:0] RES_CHAR = 2'd0;
  localparam logic [1:0] RES_END  = 2'd1;
  localparam logic [1:0] RES_DONE = 2'd2;

  localparam logic [7:0]  WS_MAX    = 8'd32;
  localparam logic [7:0]  CH_QUOTE  = 8'd34;
  localparam logic [7:0]  CH_SEMI   = 8'h3B;
  localparam logic [7:0]  CH_NL     = 8'h0A;
  localparam logic [23:0] LINE_MAX  = 24'hFFFFFF;
  localparam logic [23:0] LINE_INIT = 24'd1;

  typedef struct packed {
    logic [1:0]  kind_res;
    logic [7:0]  token_char;
    logic [23:0] line_number;
    logic        crossed_line;
    logic        was_quoted;
    logic        was_truncated;
    logic        script_done;
  } result_t;

  // One queue entry: the results of one input byte.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  typedef struct packed {
    logic   empty;
    entry_t head;
  } head_t;

  function automatic result_t mk_res(logic [1:0] k, logic [7:0] ch, logic [23:0] ln,
                                     logic cr, logic q, logic t, logic d);
    result_t r;
    r.kind_res      = k;
    r.token_char    = ch;
    r.line_number   = ln;
    r.crossed_line  = cr;
    r.was_quoted    = q;
    r.was_truncated = t;
    r.script_done   = d;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/sts_if.sv =====
// Valid/ready channel interfaces for script bytes and scanner results.
// Depends on nothing.
`default_nettype none
interface sts_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] script_byte;
  logic       final_byte;
  modport source (output valid, output kind, output script_byte, output final_byte,
                  input ready);
  modport sink (input valid, input kind, input script_byte, input final_byte,
                output ready);
endinterface

interface sts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind_res;
  logic [7:0]  token_char;
  logic [23:0] line_number;
  logic        crossed_line;
  logic        was_quoted;
  logic        was_truncated;
  logic        script_done;
  modport source (output valid, output kind_res, output token_char, output line_number,
                  output crossed_line, output was_quoted, output was_truncated,
                  output script_done, input ready);
  modport sink (input valid, input kind_res, input token_char, input line_number,
                input crossed_line, input was_quoted, input was_truncated,
                input script_done, output ready);
endinterface
`default_nettype wire

// ===== src/sts_front.sv =====
// Front end: accepts script bytes, runs the scan mode machine and builds
// the results (none, one or two) of each byte. Depends on sts_pkg and sts_if.
`default_nettype none
module sts_front import sts_pkg::*; #(
  parameter int unsigned MaxTokenBytes = MAX_TOKEN_BYTES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sts_in_if.sink    in_i,
  input  wire logic full_i,
  output logic      push_o,
  output entry_t    entry_o
);

  localparam int unsigned LEN_W = $clog2(MaxTokenBytes);
  localparam logic [LEN_W:0] LIMIT = (LEN_W + 1)'(MaxTokenBytes - 1);

  localparam logic [2:0] MODE_SKIP    = 3'd0;
  localparam logic [2:0] MODE_COMMENT = 3'd1;
  localparam logic [2:0] MODE_NORMAL  = 3'd2;
  localparam logic [2:0] MODE_QUOTED  = 3'd3;
  localparam logic [2:0] MODE_DISCARD = 3'd4;

  logic [2:0]       mode_q, mode_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [23:0]      line_q, line_d;
  logic             cross_q, cross_d;
  logic             fin_q, fin_d;

  logic [7:0]       b;
  logic             fb, is_ws, is_nl, is_semi, is_quote;
  logic [23:0]      line_inc;
  logic [1:0]       cnt;
  result_t          r0, r1;
  logic             do_take, take_q, trunc;
  logic [LEN_W-1:0] take_base;
  logic [LEN_W:0]   len_sum;

  assign b        = in_i.script_byte;
  assign fb       = in_i.final_byte;
  assign is_ws    = (b <= WS_MAX);
  assign is_nl    = (b == CH_NL);
  assign is_semi  = (b == CH_SEMI);
  assign is_quote = (b == CH_QUOTE);
  assign line_inc = (line_q != LINE_MAX) ? line_q + 24'd1 : line_q;

  always_comb begin
    mode_d    = mode_q;
    len_d     = len_q;
    line_d    = line_q;
    cross_d   = cross_q;
    fin_d     = fin_q;
    cnt       = 2'd0;
    r0        = '0;
    r1        = '0;
    do_take   = 1'b0;
    take_q    = 1'b0;
    take_base = '0;
    trunc     = 1'b0;
    len_sum   = '0;
    if (in_i.kind == KIND_RESTART) begin
      mode_d  = MODE_SKIP;
      len_d   = '0;
      line_d  = LINE_INIT;
      cross_d = 1'b0;
      fin_d   = 1'b0;
    end else if (fin_q) begin
      cnt = 2'd1;
      r0  = mk_res(RES_DONE, 8'd0, line_q, cross_q, 1'b0, 1'b0, 1'b1);
    end else begin
      unique case (mode_q)
        MODE_COMMENT: begin
          if (is_nl) begin
            line_d  = line_inc;
            cross_d = 1'b1;
            mode_d  = MODE_SKIP;
          end
          if (fb) begin
            fin_d  = 1'b1;
            mode_d = MODE_SKIP;
            cnt    = 2'd1;
            r0     = mk_res(RES_DONE, 8'd0, line_d, cross_d, 1'b0, 1'b0, 1'b1);
          end
        end
        MODE_DISCARD: begin
          mode_d = MODE_SKIP;
          if (fb) begin
            fin_d = 1'b1;
            cnt   = 2'd1;
            r0    = mk_res(RES_DONE, 8'd0, line_q, cross_q, 1'b0, 1'b0, 1'b1);
          end
        end
        MODE_QUOTED: begin
          if (is_quote) begin
            cnt     = 2'd1;
            r0      = mk_res(RES_END, 8'd0, line_q, cross_q, 1'b1, 1'b0, fb);
            cross_d = 1'b0;
            len_d   = '0;
            fin_d   = fb;
            mode_d  = MODE_SKIP;
          end else begin
            do_take   = 1'b1;
            take_q    = 1'b1;
            take_base = len_q;
          end
        end
        MODE_NORMAL: begin
          if (is_ws || is_semi) begin
            cnt     = 2'd1;
            r0      = mk_res(RES_END, 8'd0, line_q, cross_q, 1'b0, 1'b0, 1'b0);
            cross_d = 1'b0;
            len_d   = '0;
            mode_d  = MODE_SKIP;
            if (is_nl) begin
              line_d  = line_inc;
              cross_d = 1'b1;
            end
            if (is_semi) begin
              mode_d = MODE_COMMENT;
            end
            if (fb) begin
              fin_d  = 1'b1;
              mode_d = MODE_SKIP;
              cnt    = 2'd2;
              r1     = mk_res(RES_DONE, 8'd0, line_d, cross_d, 1'b0, 1'b0, 1'b1);
            end
          end else begin
            do_take   = 1'b1;
            take_base = len_q;
          end
        end
        default: begin
          mode_d = MODE_SKIP;
          if (is_ws) begin
            if (is_nl) begin
              line_d  = line_inc;
              cross_d = 1'b1;
            end
            if (fb) begin
              fin_d = 1'b1;
              cnt   = 2'd1;
              r0    = mk_res(RES_DONE, 8'd0, line_d, cross_d, 1'b0, 1'b0, 1'b1);
            end
          end else if (is_semi) begin
            mode_d = MODE_COMMENT;
            if (fb) begin
              fin_d  = 1'b1;
              mode_d = MODE_SKIP;
              cnt    = 2'd1;
              r0     = mk_res(RES_DONE, 8'd0, line_q, cross_q, 1'b0, 1'b0, 1'b1);
            end
          end else if (is_quote) begin
            len_d  = '0;
            mode_d = MODE_QUOTED;
            if (fb) begin
              cnt     = 2'd1;
              r0      = mk_res(RES_END, 8'd0, line_q, cross_q, 1'b1, 1'b0, 1'b1);
              cross_d = 1'b0;
              fin_d   = 1'b1;
              mode_d  = MODE_SKIP;
            end
          end else begin
            do_take = 1'b1;
          end
        end
      endcase
      if (do_take) begin
        len_sum = {1'b0, take_base} + {{LEN_W{1'b0}}, 1'b1};
        trunc   = (len_sum >= LIMIT);
        cnt     = 2'd1;
        r0      = mk_res(RES_CHAR, b, line_q, cross_q, take_q, 1'b0, 1'b0);
        len_d   = len_sum[LEN_W-1:0];
        mode_d  = take_q ? MODE_QUOTED : MODE_NORMAL;
        if (fb || trunc) begin
          cnt     = 2'd2;
          r1      = mk_res(RES_END, 8'd0, line_q, cross_q, take_q, trunc, fb);
          cross_d = 1'b0;
          len_d   = '0;
          fin_d   = fb;
          mode_d  = (take_q && trunc && !fb) ? MODE_DISCARD : MODE_SKIP;
        end
      end
    end
  end

  logic accept;
  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign push_o     = accept && (cnt != 2'd0);
  assign entry_o    = '{two: (cnt == 2'd2), r0: r0, r1: r1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_SKIP;
      len_q   <= '0;
      line_q  <= LINE_INIT;
      cross_q <= 1'b0;
      fin_q   <= 1'b0;
    end else if (accept) begin
      mode_q  <= mode_d;
      len_q   <= len_d;
      line_q  <= line_d;
      cross_q <= cross_d;
      fin_q   <= fin_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/sts_queue.sv =====
// Short result queue between front and back end.
// Depends on sts_pkg.
`default_nettype none
module sts_queue import sts_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t entry_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output head_t       head_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o       = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign head_o.empty = (cnt_q == '0);
  assign head_o.head  = mem_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && !head_o.empty;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/sts_back.sv =====
// Back end: drains queue entries onto the result channel, one result per
// transfer. Depends on sts_pkg and sts_if.
`default_nettype none
module sts_back import sts_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire head_t head_i,
  output logic       pop_o,
  sts_out_if.source  out_o
);

  logic    sub_q, sub_d;
  logic    xfer;
  result_t cur;

  assign cur         = sub_q ? head_i.head.r1 : head_i.head.r0;
  assign out_o.valid = !head_i.empty;
  assign xfer        = out_o.valid && out_o.ready;

  assign out_o.kind_res      = cur.kind_res;
  assign out_o.token_char    = cur.token_char;
  assign out_o.line_number   = cur.line_number;
  assign out_o.crossed_line  = cur.crossed_line;
  assign out_o.was_quoted    = cur.was_quoted;
  assign out_o.was_truncated = cur.was_truncated;
  assign out_o.script_done   = cur.script_done;

  always_comb begin
    sub_d = sub_q;
    pop_o = 1'b0;
    if (xfer) begin
      if (head_i.head.two && !sub_q) begin
        sub_d = 1'b1;
      end else begin
        sub_d = 1'b0;
        pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= 1'b0;
    end else begin
      sub_q <= sub_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/script_token_scanner.sv =====
// Script token scanner: one script byte accepted per cycle while the
// four-entry result queue has room. Results are registered in the queue and
// offered in order behind older entries; a byte with two results (char plus
// end marker, or end plus done marker) occupies the output for two transfers, so output rate bounds throughput.
// Asynchronous active-low reset: mode skip, line count 1, queue empty.
// Depends on sts_pkg, sts_if, sts_front, sts_queue, sts_back.
`default_nettype none
module script_token_scanner import sts_pkg::*; #(
  parameter int unsigned MaxTokenBytes = MAX_TOKEN_BYTES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sts_in_if.sink    in_i,
  sts_out_if.source out_o
);

  logic   push, full, pop;
  entry_t entry;
  head_t  head;

  sts_front #(.MaxTokenBytes(MaxTokenBytes)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  sts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head)
  );

  sts_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire

// ===== src/sts_checker.sv =====
// Port-level checks on the scanner result channel, bound to the top level.
// Depends on sts_pkg.
`default_nettype none
module sts_checker import sts_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        valid_i,
  input wire logic        ready_i,
  input wire logic [1:0]  kind_res_i,
  input wire logic [7:0]  token_char_i,
  input wire logic [23:0] line_number_i,
  input wire logic        was_truncated_i,
  input wire logic        script_done_i
);

  a_done_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && kind_res_i == RES_DONE |-> script_done_i)
    else $error("script-ended result without done flag");

  a_char_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && kind_res_i == RES_CHAR |-> !was_truncated_i && !script_done_i)
    else $error("token character carries end flags");

  a_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && kind_res_i != RES_CHAR |-> token_char_i == 8'd0)
    else $error("non-character result with character data");

  a_line_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> line_number_i != 24'd0)
    else $error("line count zero");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(kind_res_i) && $stable(token_char_i))
    else $error("stalled result changed");

endmodule

bind script_token_scanner sts_checker u_sts_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .valid_i         (out_o.valid),
  .ready_i         (out_o.ready),
  .kind_res_i      (out_o.kind_res),
  .token_char_i    (out_o.token_char),
  .line_number_i   (out_o.line_number),
  .was_truncated_i (out_o.was_truncated),
  .script_done_i   (out_o.script_done)
);
`default_nettype wire
